// File: rtl/srlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlt_pkg
// Types and codes shared by the square region lock table modules.
// ----------------------------------------------------------------------------
package srlt_pkg;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CONFLICT  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RADIUS    = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] center_x;
    logic signed [31:0] center_z;
    logic signed [7:0]  radius;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [4:0] held_count;
  } out_word_t;

  // One stored area.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] z;
    logic [6:0]  r;
  } entry_t;

  // Tag that travels with one slot read through the compare pipeline.
  typedef struct packed {
    logic act;
    logic ent_valid;
    logic last;
  } scan_tag_t;

  // Outcome of one slot compare.
  typedef struct packed {
    logic valid;
    logic last;
    logic clash;
    logic match;
  } scan_res_t;

endpackage
`default_nettype wire

// File: rtl/srlt_entry_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlt_entry_mem
// Single-port-write, single-read entry store with registered read data.
// ----------------------------------------------------------------------------
module srlt_entry_mem #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IW-1:0]   wr_addr,
  input  wire srlt_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [IW-1:0]   rd_addr,
  output srlt_pkg::entry_t     rd_data
);

  srlt_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/srlt_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlt_cmp
// Overlap and exact-match comparator for one table slot per cycle.
// ----------------------------------------------------------------------------
module srlt_cmp #(
  parameter int IW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       req_x,
  input  wire logic [31:0]       req_z,
  input  wire logic [6:0]        req_r,
  input  wire srlt_pkg::scan_tag_t issue_tag,
  input  wire logic [IW-1:0]     issue_idx,
  input  wire srlt_pkg::entry_t  rd_data,
  output srlt_pkg::scan_res_t    res,
  output logic [IW-1:0]          res_idx
);

  srlt_pkg::scan_tag_t tag1;
  srlt_pkg::scan_tag_t tag2;
  logic [IW-1:0]       idx1;
  logic [IW-1:0]       idx2;
  logic signed [32:0]  dx;
  logic signed [32:0]  dz;
  logic [7:0]          lim;
  logic                same;
  logic [32:0]         mag_x;
  logic [32:0]         mag_z;

  // Stage 1 follows the memory read; stage 2 holds the exact differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= issue_tag;
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= issue_idx;
    idx2 <= idx1;
    dx   <= $signed({req_x[31], req_x}) - $signed({rd_data.x[31], rd_data.x});
    dz   <= $signed({req_z[31], req_z}) - $signed({rd_data.z[31], rd_data.z});
    lim  <= {1'b0, req_r} + {1'b0, rd_data.r};
    same <= (rd_data.x == req_x) && (rd_data.z == req_z) && (rd_data.r == req_r);
  end

  // Differences never reach -2^32, so the magnitude fits in 33 bits.
  assign mag_x = dx[32] ? 33'(-dx) : 33'(dx);
  assign mag_z = dz[32] ? 33'(-dz) : 33'(dz);

  always_comb begin
    res.valid = tag2.act;
    res.last  = tag2.act && tag2.last;
    res.clash = tag2.act && tag2.ent_valid && (mag_x <= 33'(lim)) && (mag_z <= 33'(lim));
    res.match = tag2.act && tag2.ent_valid && same;
  end

  assign res_idx = idx2;

endmodule
`default_nettype wire

// File: rtl/square_region_lock_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Each request scans every slot before its result is valid; an oversize radius
// skips the scan. The slot scan reads one table entry per cycle through a single
// memory port, and a new request is only taken once the previous one has finished.
// A new request is taken while the previous result still waits in the output.
// Reset clears all valid bits and the held count at once; entry storage is
// not cleared and is only read behind a valid bit.
// ----------------------------------------------------------------------------
// square_region_lock_table
// Lock table for square grid areas: query, acquire and release with a
// sequential scan of the entry memory.
// ----------------------------------------------------------------------------
module square_region_lock_table #(
  parameter int SLOTS      = 16,
  parameter int MAX_RADIUS = 127
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire srlt_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output srlt_pkg::out_word_t     out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [6:0]    MAX_R  = 7'(MAX_RADIUS);
  localparam logic [CW-1:0] LAST_I = CW'(SLOTS - 1);
  localparam logic [CW-1:0] NSLOTS = CW'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_ERR    = 4'b1000
  } state_t;

  state_t          state;
  logic [1:0]      req_op;
  logic [31:0]     req_x;
  logic [31:0]     req_z;
  logic [6:0]      req_r;
  logic [6:0]      r_clamped;
  logic [SLOTS-1:0] valid_bits;
  logic [CW-1:0]   held_total;
  logic [CW-1:0]   held_next;
  logic [CW-1:0]   issue_cnt;
  logic            issuing;
  logic            clash_found;
  logic [IW-1:0]   clash_idx;
  logic            match_found;
  logic [IW-1:0]   match_idx;
  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic            out_free;
  logic            mem_wr;
  logic [2:0]      status_next;
  logic [IW-1:0]   slot_next;

  srlt_pkg::entry_t    wr_data;
  srlt_pkg::entry_t    rd_data;
  srlt_pkg::scan_tag_t issue_tag;
  srlt_pkg::scan_res_t res;
  logic [IW-1:0]       res_idx;

  assign in_ready  = (state == S_IDLE);
  assign r_clamped = in_data.radius[7] ? 7'd0 : in_data.radius[6:0];
  assign issuing   = (state == S_SCAN) && (issue_cnt != NSLOTS);
  assign out_free  = !out_valid || out_ready;

  assign issue_tag.act       = issuing;
  assign issue_tag.ent_valid = valid_bits[issue_cnt[IW-1:0]];
  assign issue_tag.last      = (issue_cnt == LAST_I);

  assign wr_data.x = req_x;
  assign wr_data.z = req_z;
  assign wr_data.r = req_r;

  srlt_entry_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (free_idx),
    .wr_data (wr_data),
    .rd_en   (issuing),
    .rd_addr (issue_cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  srlt_cmp #(.IW(IW)) u_cmp (
    .clk       (clk),
    .rst       (rst),
    .req_x     (req_x),
    .req_z     (req_z),
    .req_r     (req_r),
    .issue_tag (issue_tag),
    .issue_idx (issue_cnt[IW-1:0]),
    .rd_data   (rd_data),
    .res       (res),
    .res_idx   (res_idx)
  );

  // Outcome of the finished scan; any other state gives the radius error status.
  always_comb begin
    status_next = srlt_pkg::ST_OK;
    slot_next   = '0;
    held_next   = held_total;
    mem_wr      = 1'b0;
    if (state == S_FINISH) begin
      if (req_op == srlt_pkg::OP_RELEASE) begin
        if (match_found) begin
          slot_next = match_idx;
          held_next = held_total - CW'(1);
        end else begin
          status_next = srlt_pkg::ST_NOT_FOUND;
        end
      end else if (clash_found) begin
        status_next = srlt_pkg::ST_CONFLICT;
        slot_next   = clash_idx;
      end else if (req_op == srlt_pkg::OP_ACQUIRE) begin
        if (free_found) begin
          slot_next = free_idx;
          held_next = held_total + CW'(1);
          mem_wr    = out_free;
        end else begin
          status_next = srlt_pkg::ST_FULL;
        end
      end
    end else begin
      status_next = srlt_pkg::ST_RADIUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      held_total <= '0;
      out_valid  <= 1'b0;
      issue_cnt  <= '0;
    end else begin
      // A new word loads the output as soon as the old one leaves.
      out_valid <= ((state == S_FINISH || state == S_ERR) && out_free) ||
                   (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            issue_cnt <= '0;
            state     <= (r_clamped > MAX_R) ? S_ERR : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (res.last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH, S_ERR: begin
          if (out_free) begin
            held_total <= held_next;
            state      <= S_IDLE;
            if (state == S_FINISH && status_next == srlt_pkg::ST_OK) begin
              if (req_op == srlt_pkg::OP_RELEASE) begin
                valid_bits[match_idx] <= 1'b0;
              end else if (req_op == srlt_pkg::OP_ACQUIRE) begin
                valid_bits[free_idx] <= 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture, scan bookkeeping and the output word.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_op      <= in_data.op;
      req_x       <= in_data.center_x;
      req_z       <= in_data.center_z;
      req_r       <= r_clamped;
      clash_found <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end
    if (issuing && !issue_tag.ent_valid && !free_found) begin
      free_found <= 1'b1;
      free_idx   <= issue_cnt[IW-1:0];
    end
    if (res.clash && !clash_found) begin
      clash_found <= 1'b1;
      clash_idx   <= res_idx;
    end
    if (res.match && !match_found) begin
      match_found <= 1'b1;
      match_idx   <= res_idx;
    end
    if ((state == S_FINISH || state == S_ERR) && out_free) begin
      out_data.status     <= status_next;
      out_data.slot       <= 4'(slot_next);
      out_data.held_count <= 5'(held_next);
    end
  end

  a_count_matches_bits: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_bits) == held_total)
    else $error("held count differs from number of valid slots");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    held_total <= NSLOTS)
    else $error("held count exceeds table size");

  a_count_changes_at_finish: assert property (@(posedge clk) disable iff (rst)
    !$stable(held_total) |-> $past(state == S_FINISH))
    else $error("held count changed outside a finishing request");

  a_results_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> state == S_SCAN)
    else $error("compare result outside a scan");

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for square_region_lock_table. Query, acquire and
// release words go in through a bursty sender. A local copy of the lock table
// predicts each result, and the status, slot and held count of every result
// are checked in order while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS      = 16;
  localparam int MAX_RADIUS = 127;
  localparam int LATENCY    = SLOTS + 3;
  localparam int TIMEOUT_NS = 5_000_000;

  // The op encoding leaves one value unused; the block treats it as a query.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam logic [6:0] RX_PATTERN_BITS = 7'b1011001;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  srlt_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  srlt_pkg::out_word_t out_data;

  // Local copy of the lock table.
  logic        lock_on [SLOTS];
  logic [31:0] lock_x  [SLOTS];
  logic [31:0] lock_z  [SLOTS];
  logic [6:0]  lock_r  [SLOTS];
  logic [4:0]  lock_total;

  srlt_pkg::out_word_t pending_q[$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          status_seen[8];

  int          burst_left = 0;
  int          rx_mode = RX_ALWAYS;
  int          hold_left = 0;
  int          rx_phase = 0;
  logic [31:0] cluster_x;
  logic [31:0] cluster_z;

  always #6 clk = ~clk;

  square_region_lock_table #(
    .SLOTS     (SLOTS),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  function automatic int clamp_radius(logic [7:0] r);
    return r[7] ? 0 : int'(r[6:0]);
  endfunction

  function automatic srlt_pkg::out_word_t predict_lock(srlt_pkg::in_word_t w);
    srlt_pkg::out_word_t res;
    int        rr;
    int        hit;
    longint    dx;
    longint    dz;
    longint    lim;
    res = '0;
    hit = -1;
    rr  = clamp_radius(w.radius);
    if (rr > MAX_RADIUS) begin
      res.status = srlt_pkg::ST_RADIUS;
    end else if (w.op == srlt_pkg::OP_RELEASE) begin
      res.status = srlt_pkg::ST_NOT_FOUND;
      for (int i = 0; i < SLOTS; i++) begin
        if (lock_on[i] && lock_x[i] == w.center_x && lock_z[i] == w.center_z &&
            int'(lock_r[i]) == rr) begin
          lock_on[i] = 1'b0;
          if (lock_total != 0) lock_total--;
          res.status = srlt_pkg::ST_OK;
          res.slot   = i[3:0];
          break;
        end
      end
    end else begin
      // Distances are taken at full precision, so areas never wrap at the edges.
      for (int i = 0; i < SLOTS && hit < 0; i++) begin
        if (lock_on[i]) begin
          lim = longint'(rr) + longint'(lock_r[i]);
          dx  = longint'($signed(w.center_x)) - longint'($signed(lock_x[i]));
          dz  = longint'($signed(w.center_z)) - longint'($signed(lock_z[i]));
          if (dx < 0) dx = -dx;
          if (dz < 0) dz = -dz;
          if (dx <= lim && dz <= lim) hit = i;
        end
      end
      if (hit >= 0) begin
        res.status = srlt_pkg::ST_CONFLICT;
        res.slot   = hit[3:0];
      end else if (w.op == srlt_pkg::OP_ACQUIRE) begin
        res.status = srlt_pkg::ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!lock_on[i]) begin
            lock_on[i] = 1'b1;
            lock_x[i]  = w.center_x;
            lock_z[i]  = w.center_z;
            lock_r[i]  = rr[6:0];
            lock_total++;
            res.status = srlt_pkg::ST_OK;
            res.slot   = i[3:0];
            break;
          end
        end
      end
    end
    res.held_count = lock_total;
    return res;
  endfunction

  function automatic srlt_pkg::in_word_t make_word(logic [1:0] op, int x, int z, int r);
    srlt_pkg::in_word_t w;
    w.op       = op;
    w.center_x = x;
    w.center_z = z;
    w.radius   = 8'(r);
    return w;
  endfunction

  // Bursts of back-to-back words separated by random gaps.
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 10);
    return $urandom_range(1, 9);
  endfunction

  function automatic logic [31:0] random_coord(logic [31:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return base + int'($urandom_range(0, 80)) - 40;
      4, 5:       return $urandom();
      6, 7:       return $urandom_range(0, 1) ? 32'h7FFF_FF80 + $urandom_range(0, 127)
                                               : 32'h8000_0000 + $urandom_range(0, 127);
      default:    return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic srlt_pkg::in_word_t random_request();
    srlt_pkg::in_word_t w;
    int       live[$];
    int       pick;
    int       idx;
    int       reach;
    int       dx;
    int       dz;
    for (int i = 0; i < SLOTS; i++) begin
      if (lock_on[i]) live.insert(live.size(), i);
    end
    pick = $urandom_range(0, 99);
    w.op = (pick < 40) ? srlt_pkg::OP_ACQUIRE : (pick < 70) ? srlt_pkg::OP_RELEASE :
           (pick < 95) ? srlt_pkg::OP_QUERY : OP_SPARE;
    case ($urandom_range(0, 7))
      0, 1, 2: w.radius = 8'($urandom_range(0, 12));
      3, 4:    w.radius = 8'($urandom_range(0, 127));
      5:       w.radius = 8'($urandom_range(128, 255));
      6:       w.radius = 8'(MAX_RADIUS);
      default: w.radius = 8'($urandom_range(0, 3));
    endcase
    if (live.size() != 0 && $urandom_range(0, 99) < 25) begin
      // Land just inside, right on or just past the edge of a held area.
      idx   = live[$urandom_range(0, live.size() - 1)];
      reach = clamp_radius(w.radius) + int'(lock_r[idx]);
      dx    = reach + int'($urandom_range(0, 2)) - 1;
      dz    = int'($urandom_range(0, reach + 1));
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dz = -dz;
      if ($urandom_range(0, 1)) begin
        w.center_x = lock_x[idx] + dx;
        w.center_z = lock_z[idx] + dz;
      end else begin
        w.center_x = lock_x[idx] + dz;
        w.center_z = lock_z[idx] + dx;
      end
    end else begin
      w.center_x = random_coord(cluster_x);
      w.center_z = random_coord(cluster_z);
    end
    if (w.op == srlt_pkg::OP_RELEASE && live.size() != 0 && $urandom_range(0, 99) < 70) begin
      idx        = live[$urandom_range(0, live.size() - 1)];
      w.center_x = lock_x[idx];
      w.center_z = lock_z[idx];
      if (lock_r[idx] == 0 && $urandom_range(0, 1)) w.radius = 8'($urandom_range(128, 255));
      else w.radius = {1'b0, lock_r[idx]};
    end
    return w;
  endfunction

  task automatic send_word(input srlt_pkg::in_word_t w, input int gap);
    srlt_pkg::out_word_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    res = predict_lock(w);
    pending_q.insert(pending_q.size(), res);
    sent++;
    status_seen[res.status]++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: MISMATCH on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    srlt_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result word with nothing pending", int'(out_data), 0);
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.slot !== want.slot)
          report_mismatch("slot", out_data.slot, want.slot);
        if (out_data.held_count !== want.held_count)
          report_mismatch("held_count", out_data.held_count, want.held_count);
      end
    end
  end

  // Receiver: a long hold-off takes priority over the selected stall pattern.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      case (rx_mode)
        RX_RANDOM: begin
          out_ready <= ($urandom_range(0, 99) >= 40);
          if ($urandom_range(0, 99) < 2) hold_left = $urandom_range(5, 40);
        end
        RX_PATTERN: begin
          out_ready <= RX_PATTERN_BITS[rx_phase];
          rx_phase = (rx_phase + 1) % 7;
        end
        default: begin
          out_ready <= 1'b1;
        end
      endcase
    end
  end

  task automatic test_directed_edges();
    rx_mode = RX_RANDOM;
    send_word(make_word(srlt_pkg::OP_QUERY, 0, 0, 0), next_gap());
    send_word(make_word(srlt_pkg::OP_ACQUIRE, 0, 0, 5), next_gap());
    send_word(make_word(srlt_pkg::OP_ACQUIRE, 10, -10, 5), next_gap());
    send_word(make_word(srlt_pkg::OP_ACQUIRE, 11, 0, 5), next_gap());
    send_word(make_word(srlt_pkg::OP_QUERY, 5, 10, 0), next_gap());
    send_word(make_word(srlt_pkg::OP_QUERY, 5, 10, 5), next_gap());
    // Negative radii count as zero, for acquire and release alike.
    send_word(make_word(srlt_pkg::OP_ACQUIRE, 1000, 1000, -3), next_gap());
    send_word(make_word(srlt_pkg::OP_QUERY, 1000, 1000, -128), next_gap());
    send_word(make_word(srlt_pkg::OP_RELEASE, 1000, 1000, -1), next_gap());
    send_word(make_word(srlt_pkg::OP_RELEASE, 1000, 1000, 0), next_gap());
    send_word(make_word(srlt_pkg::OP_RELEASE, 0, 0, 4), next_gap());
    // Areas at opposite ends of the coordinate range must not meet.
    send_word(make_word(srlt_pkg::OP_ACQUIRE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 127), next_gap());
    send_word(make_word(srlt_pkg::OP_QUERY, 32'h8000_0000, 32'h8000_0000, 127), next_gap());
    send_word(make_word(srlt_pkg::OP_QUERY, 32'h7FFF_FF01, 32'h7FFF_FF01, 127), next_gap());
    send_word(make_word(srlt_pkg::OP_QUERY, 32'h7FFF_FF00, 32'h7FFF_FF00, 127), next_gap());
    send_word(make_word(srlt_pkg::OP_ACQUIRE, 32'h8000_0000, 32'h8000_0000, 127), next_gap());
    send_word(make_word(OP_SPARE, 0, 0, 0), next_gap());
    send_word(make_word(OP_SPARE, 12345, -54321, 0), next_gap());
    send_word(make_word(srlt_pkg::OP_RELEASE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 127), next_gap());
    send_word(make_word(srlt_pkg::OP_RELEASE, 0, 0, 5), next_gap());
    send_word(make_word(srlt_pkg::OP_RELEASE, 11, 0, 5), next_gap());
    send_word(make_word(srlt_pkg::OP_RELEASE, 32'h8000_0000, 32'h8000_0000, 127), next_gap());
    drain_results();
  endtask

  task automatic test_fill_and_empty();
    int        tries;
    int        mid;
    int        held[$];
    srlt_pkg::in_word_t w;
    rx_mode = RX_PATTERN;
    tries   = 0;
    while (lock_total < SLOTS && tries < 40) begin
      w = make_word(srlt_pkg::OP_ACQUIRE, $urandom(), $urandom(), $urandom_range(0, 127));
      send_word(w, 0);
      tries++;
    end
    send_word(make_word(srlt_pkg::OP_ACQUIRE, $urandom(), $urandom(), 0), 0);
    // A clash is reported ahead of the full table.
    for (int i = 0; i < SLOTS; i++) begin
      if (lock_on[i]) held.insert(held.size(), i);
    end
    mid = held[held.size() / 2];
    w   = make_word(srlt_pkg::OP_ACQUIRE, lock_x[mid], lock_z[mid], 0);
    send_word(w, 0);
    send_word(make_word(srlt_pkg::OP_QUERY, $urandom(), $urandom(), 127), 0);
    held.shuffle();
    foreach (held[k]) begin
      w = make_word(srlt_pkg::OP_RELEASE, lock_x[held[k]], lock_z[held[k]], lock_r[held[k]]);
      send_word(w, 0);
    end
    w = make_word(srlt_pkg::OP_RELEASE, lock_x[held[0]], lock_z[held[0]], lock_r[held[0]]);
    send_word(w, 0);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    rx_mode   = RX_ALWAYS;
    cluster_x = $urandom();
    cluster_z = $urandom();
    send_word(random_request(), 0);
    hold_left = 300;
    // The sender keeps offering words until the block stops taking them.
    repeat (24) send_word(random_request(), 0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int mode, input bit gaps);
    rx_mode   = mode;
    cluster_x = $urandom_range(0, 1) ? $urandom() : 32'h7FFF_FFE0;
    cluster_z = $urandom_range(0, 1) ? $urandom() : 32'h8000_0010;
    for (int n = 1; n <= count; n++) begin
      send_word(random_request(), gaps ? next_gap() : 0);
      if (n % 100 == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d words sent, %0d results still pending", sent, pending_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) lock_on[i] = 1'b0;
    lock_total = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_fill_and_empty();
    test_output_backpressure();
    test_random_traffic(250, RX_RANDOM, 1'b1);
    test_random_traffic(200, RX_PATTERN, 1'b1);
    test_random_traffic(150, RX_ALWAYS, 1'b0);
    test_random_traffic(200, RX_RANDOM, 1'b0);

    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    $display("Covered %0d requests, %0d results checked, with edge coordinates, negative",
             sent, checked);
    $display("radii, a full table, long output stalls: %0d ok, %0d conflict, %0d full, %0d absent",
             status_seen[srlt_pkg::ST_OK], status_seen[srlt_pkg::ST_CONFLICT],
             status_seen[srlt_pkg::ST_FULL], status_seen[srlt_pkg::ST_NOT_FOUND]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
